@@ src/iir_df1_pkg.sv @@
// ----------------------------------------------------------------------------
// IIR direct form I filter package
// Widths, coefficient register map and shared types of the filter.
// ----------------------------------------------------------------------------
package iir_df1_pkg;

  localparam int SAMPLE_W  = 16;             // audio sample width
  localparam int COEF_W    = 18;             // Q4.14 coefficient width
  localparam int YHIST_W   = 24;             // output history width, 8 fraction bits
  localparam int ACC_W     = 44;             // exact sum of all products, 22 fraction bits
  localparam int MAX_ORDER = 4;              // coefficient map is laid out for this order
  localparam int ORDER_DEF = 4;
  localparam int NUM_COEF  = 2 * MAX_ORDER - 1;
  localparam int CFG_IDX_W = 3;

  // Fraction bits dropped when forming the history value and the output sample.
  localparam int YHIST_SHIFT = 14;
  localparam int OUT_SHIFT   = 22;
  localparam int FEED_SCALE  = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [YHIST_W-1:0]  yval_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEED_COEF_0 = 3'd0,
    REG_FEED_COEF_1 = 3'd1,
    REG_FEED_COEF_2 = 3'd2,
    REG_FEED_COEF_3 = 3'd3,
    REG_BACK_COEF_1 = 3'd4,
    REG_BACK_COEF_2 = 3'd5,
    REG_BACK_COEF_3 = 3'd6
  } cfg_reg_t;

  // b0 resets to unity gain, every other coefficient to zero.
  localparam coef_t COEF0_RESET = 18'sd16384;

endpackage

@@ src/iir_df1_mac.sv @@
// ----------------------------------------------------------------------------
// IIR direct form I multiply-accumulate
// Forms the feedforward and feedback products for one sample, sums them
// exactly and produces the rounded, saturated output and history values.
// ----------------------------------------------------------------------------
module iir_df1_mac
  import iir_df1_pkg::*;
#(
  parameter int ORDER = ORDER_DEF
) (
  input  coef_t   coef     [NUM_COEF],
  input  sample_t x_vec    [ORDER],
  input  yval_t   y_vec    [ORDER-1],
  output sample_t y_sample,
  output yval_t   y_hist
);

  localparam int PB_W = COEF_W + SAMPLE_W;
  localparam int PA_W = COEF_W + YHIST_W;

  logic signed [PB_W-1:0] prod_b [ORDER];
  logic signed [PA_W-1:0] prod_a [ORDER-1];
  acc_t acc;
  acc_t hist_rnd;
  acc_t hist_sh;
  acc_t out_rnd;
  acc_t out_sh;

  for (genvar k = 0; k < ORDER; k++) begin : g_feed
    assign prod_b[k] = coef[k] * x_vec[k];
  end

  // Feedback coefficient a[k] sits right after the feedforward block.
  for (genvar k = 1; k < ORDER; k++) begin : g_back
    assign prod_a[k-1] = coef[MAX_ORDER-1+k] * y_vec[k-1];
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < ORDER; k++) begin
      acc = acc + (ACC_W'(prod_b[k]) <<< FEED_SCALE);
    end
    for (int k = 0; k < ORDER - 1; k++) begin
      acc = acc - ACC_W'(prod_a[k]);
    end
  end

  assign hist_rnd = acc + (ACC_W'(1) <<< (YHIST_SHIFT - 1));
  assign hist_sh  = hist_rnd >>> YHIST_SHIFT;
  assign out_rnd  = acc + (ACC_W'(1) <<< (OUT_SHIFT - 1));
  assign out_sh   = out_rnd >>> OUT_SHIFT;

  // A value fits when all bits above its sign bit copy the sign.
  always_comb begin
    if ((&hist_sh[ACC_W-1:YHIST_W-1]) || !(|hist_sh[ACC_W-1:YHIST_W-1])) begin
      y_hist = hist_sh[YHIST_W-1:0];
    end else if (hist_sh[ACC_W-1]) begin
      y_hist = {1'b1, {(YHIST_W-1){1'b0}}};
    end else begin
      y_hist = {1'b0, {(YHIST_W-1){1'b1}}};
    end
  end

  always_comb begin
    if ((&out_sh[ACC_W-1:SAMPLE_W-1]) || !(|out_sh[ACC_W-1:SAMPLE_W-1])) begin
      y_sample = out_sh[SAMPLE_W-1:0];
    end else if (out_sh[ACC_W-1]) begin
      y_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

@@ src/iir_direct_form_one_filter_top.sv @@
// ----------------------------------------------------------------------------
// IIR direct form I filter, top level
// Filters left-channel audio samples and passes right-channel samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_sample_in, in_is_left) enter on a valid/ready channel.
//   A left item is filtered with y = sum b[k]*x[n-k] - sum a[k]*y[n-k] and
//   updates the input and output histories; a right item comes out unchanged
//   and leaves both histories alone. Each item gives exactly one result on
//   the out_ channel, in order.
//   Coefficients are written on the cfg_ channel (index 0..6 for b0..b3 and
//   a1..a3, Q4.14); cfg_ready is always high and indexes above 6 are dropped.
//   Write them only while no item is in flight.
//   From acceptance to out_valid an item passes an input register, then the
//   whole multiply-accumulate into the result register. One item is
//   accepted per cycle while the receiver takes results; the history feedback
//   closes within that single multiply-accumulate stage.
//   Reset clears both histories, sets b0 to 1.0 and all other coefficients
//   to zero, and empties both stages. While the receiver stalls, the result
//   register holds and one more item can wait in the input register.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter_top
  import iir_df1_pkg::*;
#(
  parameter int ORDER = ORDER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sample_t              in_sample_in,
  input  logic                 in_is_left,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sample_t              out_sample_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  coef_t                cfg_data
);

  coef_t   coef_r   [NUM_COEF];
  sample_t x_hist_r [ORDER-1];
  yval_t   y_hist_r [ORDER-1];
  sample_t x_vec    [ORDER];

  logic    s1_valid_r;
  sample_t s1_sample_r;
  logic    s1_left_r;
  logic    s1_adv;

  logic    out_valid_r;
  sample_t out_sample_r;

  sample_t mac_sample;
  yval_t   mac_hist;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= (i == int'(REG_FEED_COEF_0)) ? COEF0_RESET : '0;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index <= REG_BACK_COEF_3)) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // Stage 1 moves on whenever the result register is free or being emptied.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample_in;
      s1_left_r   <= in_is_left;
    end
  end

  always_comb begin
    x_vec[0] = s1_sample_r;
    for (int k = 1; k < ORDER; k++) begin
      x_vec[k] = x_hist_r[k-1];
    end
  end

  iir_df1_mac #(
    .ORDER (ORDER)
  ) u_mac (
    .coef     (coef_r),
    .x_vec    (x_vec),
    .y_vec    (y_hist_r),
    .y_sample (mac_sample),
    .y_hist   (mac_hist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ORDER - 1; k++) begin
        x_hist_r[k] <= '0;
        y_hist_r[k] <= '0;
      end
    end else if (s1_adv && s1_left_r) begin
      x_hist_r[0] <= s1_sample_r;
      y_hist_r[0] <= mac_hist;
      for (int k = 1; k < ORDER - 1; k++) begin
        x_hist_r[k] <= x_hist_r[k-1];
        y_hist_r[k] <= y_hist_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample_r <= s1_left_r ? mac_sample : s1_sample_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

`ifndef SYNTHESIS
  a_right_passes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_left_r |=> out_sample_out == $past(s1_sample_r))
    else $error("right item was not passed through unchanged");

  a_right_keeps_history: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_left_r |=> $stable(x_hist_r[0]) && $stable(y_hist_r[0]))
    else $error("right item changed the filter history");

  a_left_shifts_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_left_r |=> x_hist_r[0] == $past(s1_sample_r))
    else $error("left item did not enter the input history");

  a_stage1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_sample_r))
    else $error("waiting item in the input register was lost");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid)
    else $error("advanced item did not reach the result register");
`endif

endmodule

@@ tb/sv/iir_direct_form_one_filter_top_test.sv @@
// ----------------------------------------------------------------------------
// IIR direct form I filter testbench
// Drives left and right audio samples through the filter under several
// coefficient sets, with random stalls on both channels. A bit-true model of
// the filter kept here tracks both histories and predicts every output sample.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter_top_test;
  import iir_df1_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FILT_ORDER   = ORDER_DEF;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 104;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam coef_t COEF_MAX = 18'sh1ffff;
  localparam coef_t COEF_MIN = 18'sh20000;

  localparam longint YH_MAX  = (64'sd1 <<< (YHIST_W - 1)) - 1;
  localparam longint YH_MIN  = -(64'sd1 <<< (YHIST_W - 1));
  localparam longint SMP_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint SMP_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum {GAIN_GENTLE, GAIN_WILD, GAIN_TOP, GAIN_BOTTOM} gain_style_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    coef_t                  coef;
    sample_t                smp;
    logic                   left;
    logic                   typed;
    sample_t                want;
  } stim_row_t;

  // Item rows carry a typed result only where it follows directly from the gains.
  localparam stim_row_t DIRECTED [30] = '{
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd0,     1'b1, 1'b1, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd32767, 1'b1, 1'b1, 16'sd32767},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sh8000,  1'b1, 1'b1, 16'sh8000},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sh8000,  1'b0, 1'b1, 16'sh8000},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd32767, 1'b0, 1'b1, 16'sd32767},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd1,     1'b1, 1'b1, 16'sd1},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       -16'sd1,    1'b0, 1'b1, -16'sd1},
    '{ROW_CFG,  REG_FEED_COEF_0, 18'sd8192,    16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd1,     1'b1, 1'b1, 16'sd1},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       -16'sd1,    1'b1, 1'b1, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd3,     1'b1, 1'b1, 16'sd2},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       -16'sd3,    1'b1, 1'b1, -16'sd1},
    '{ROW_CFG,  REG_FEED_COEF_0, 18'sh1ffff,   16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd32767, 1'b1, 1'b1, 16'sd32767},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sh8000,  1'b1, 1'b1, 16'sh8000},
    '{ROW_CFG,  REG_UNUSED,      18'sd16384,   16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_FEED_COEF_0, 18'sh20000,   16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_FEED_COEF_1, 18'sd16384,   16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_FEED_COEF_2, -18'sd8192,   16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_FEED_COEF_3, 18'sd4096,    16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_BACK_COEF_1, 18'sh20000,   16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_BACK_COEF_2, 18'sh1ffff,   16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_CFG,  REG_BACK_COEF_3, 18'sd8192,    16'sd0,     1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd32767, 1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sh8000,  1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd12345, 1'b0, 1'b1, 16'sd12345},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd1000,  1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       -16'sd5000, 1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd0,     1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_UNUSED,      18'sd0,       16'sd255,   1'b1, 1'b0, 16'sd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sample_t              in_sample_in = '0;
  logic                 in_is_left = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  sample_t              out_sample_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coef_t                cfg_data = '0;

  // Filter state as the hardware should hold it.
  coef_t   feed_gain [0:MAX_ORDER-1] = '{COEF0_RESET, '0, '0, '0};
  coef_t   back_gain [1:MAX_ORDER-1] = '{'0, '0, '0};
  sample_t x_hist [0:MAX_ORDER-1]    = '{'0, '0, '0, '0};
  yval_t   y_hist [0:MAX_ORDER-2]    = '{'0, '0, '0};

  sample_t out_samples_due [$];
  sample_t due_smp;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      rx_stall = 0;
  bit      idling_on = 1'b1;

  iir_direct_form_one_filter_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_is_left     (in_is_left),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One filter step: shift histories for a left sample, return the output sample.
  function automatic sample_t iir_step(sample_t smp, logic left);
    longint acc;
    longint y_keep;
    longint y_out;
    if (!left) begin
      return smp;
    end
    for (int k = FILT_ORDER - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
    end
    x_hist[0] = smp;
    acc = 0;
    for (int k = 0; k < FILT_ORDER; k++) begin
      acc += longint'(feed_gain[k]) * longint'(x_hist[k]) * (64'sd1 <<< FEED_SCALE);
      if (k > 0) begin
        acc -= longint'(back_gain[k]) * longint'(y_hist[k-1]);
      end
    end
    for (int k = FILT_ORDER - 2; k > 0; k--) begin
      y_hist[k] = y_hist[k-1];
    end
    y_keep = (acc + (64'sd1 <<< (YHIST_SHIFT - 1))) >>> YHIST_SHIFT;
    y_keep = (y_keep > YH_MAX) ? YH_MAX : ((y_keep < YH_MIN) ? YH_MIN : y_keep);
    y_hist[0] = yval_t'(y_keep);
    y_out = (acc + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    y_out = (y_out > SMP_MAX) ? SMP_MAX : ((y_out < SMP_MIN) ? SMP_MIN : y_out);
    return sample_t'(y_out);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 5))
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(0, 128)) - 64);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return sample_t'(int'($urandom_range(0, 16000)) - 8000);
    endcase
  endfunction

  // Leaves in_valid high after the handshake unless a gap follows.
  task automatic send_item(sample_t smp, logic left, logic typed, sample_t want);
    sample_t predicted;
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    in_is_left   <= left;
    do @(posedge clk); while (!in_ready);
    predicted = iir_step(smp, left);
    out_samples_due.push_back(typed ? want : predicted);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until the filter has delivered everything.
  task automatic settle();
    in_valid <= 1'b0;
    while (out_samples_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, coef_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_COEF) begin
      if (idx < MAX_ORDER) begin
        feed_gain[idx] = value;
      end else begin
        back_gain[idx - MAX_ORDER + 1] = value;
      end
    end
  endtask

  task automatic load_coefs(gain_style_e style);
    coef_t value;
    if ($urandom_range(0, 2) == 0) begin
      write_coef(REG_UNUSED, coef_t'($urandom));
    end
    for (int r = 0; r < NUM_COEF; r++) begin
      case (style)
        GAIN_TOP:    value = COEF_MAX;
        GAIN_BOTTOM: value = COEF_MIN;
        GAIN_WILD:   value = coef_t'($urandom);
        default: begin
          // Feedback gains summing below one in magnitude keep the loop stable.
          if (r < MAX_ORDER) begin
            value = coef_t'(int'($urandom_range(0, 32768)) - 16384);
          end else begin
            value = coef_t'(int'($urandom_range(0, 8192)) - 4096);
          end
        end
      endcase
      write_coef(CFG_IDX_W'(r), value);
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (idling_on && $urandom_range(0, 9) == 0) begin
        rx_stall = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_samples_due.size() == 0) begin
        $display("%0t: output sample with none due: expected none, actual %0d",
                 $time, out_sample_out);
        mismatches++;
      end else begin
        due_smp = out_samples_due.pop_front();
        if (out_sample_out !== due_smp) begin
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, due_smp, out_sample_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   row;
    bit          cfg_open;
    gain_style_e style;
    cfg_open = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) begin
          settle();
        end
        write_coef(row.reg_idx, row.coef);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(row.smp, row.left, row.typed, row.want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        1: style = GAIN_TOP;
        3: style = GAIN_BOTTOM;
        5: style = GAIN_WILD;
        default: style = GAIN_GENTLE;
      endcase
      load_coefs(style);
      // The final phase runs with both sides at full rate.
      idling_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_item(rand_sample(), $urandom_range(0, 3) != 0, 1'b0, '0);
        if ($urandom_range(0, 199) == 0) begin
          settle();
        end
      end
    end

    in_valid <= 1'b0;
    while (out_samples_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
